// ----- src/tcw_pkg.sv -----
// tcw_pkg: item types, command and character codes, and the microprogram
// of the text console writer. No dependencies.
package tcw_pkg;

    // fixed widths of the item fields
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // character codes the commands act on
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_FIRST = 8'h21;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7E;

    // input item
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_cmd_item;

    // result item
    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [POS_W-1:0]  cursor_position;
        logic [CHAR_W-1:0] read_char;
    } t_res_item;

    // datapath micro-operations
    typedef enum logic [3:0] {
        UOP_CLR_INIT,
        UOP_CLR_LOOP,
        UOP_LATCH,
        UOP_PUT,
        UOP_SCR_INIT,
        UOP_SCR_COPY,
        UOP_FILL,
        UOP_RD_ISSUE,
        UOP_RD_CAPTURE,
        UOP_EMIT
    } t_uop;

    // sequencing conditions
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_BR_NOSCROLL,
        COND_WAIT_LAST,
        COND_WAIT_OUT,
        COND_DISPATCH
    } t_cond;

    // microprogram steps
    typedef enum logic [3:0] {
        ST_BOOT_INIT,
        ST_BOOT_LOOP,
        ST_IDLE,
        ST_PUT,
        ST_SCR_INIT,
        ST_SCR_LOOP,
        ST_FILL,
        ST_READ,
        ST_READ_CAP,
        ST_CLR_INIT,
        ST_CLR_LOOP,
        ST_DONE
    } t_step;

    // one control word of the program
    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_step target;
        logic  in_ready;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_uop uop;
        logic in_ready;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic last;
        logic no_scroll;
        logic out_free;
    } t_stat;

    // program table
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        unique case (step)
            ST_BOOT_INIT: w = '{UOP_CLR_INIT,   COND_NEXT,        ST_BOOT_LOOP, 1'b0};
            ST_BOOT_LOOP: w = '{UOP_CLR_LOOP,   COND_WAIT_LAST,   ST_IDLE,      1'b0};
            ST_IDLE:      w = '{UOP_LATCH,      COND_DISPATCH,    ST_IDLE,      1'b1};
            ST_PUT:       w = '{UOP_PUT,        COND_BR_NOSCROLL, ST_DONE,      1'b0};
            ST_SCR_INIT:  w = '{UOP_SCR_INIT,   COND_NEXT,        ST_SCR_LOOP,  1'b0};
            ST_SCR_LOOP:  w = '{UOP_SCR_COPY,   COND_WAIT_LAST,   ST_FILL,      1'b0};
            ST_FILL:      w = '{UOP_FILL,       COND_WAIT_LAST,   ST_DONE,      1'b0};
            ST_READ:      w = '{UOP_RD_ISSUE,   COND_NEXT,        ST_READ_CAP,  1'b0};
            ST_READ_CAP:  w = '{UOP_RD_CAPTURE, COND_JUMP,        ST_DONE,      1'b0};
            ST_CLR_INIT:  w = '{UOP_CLR_INIT,   COND_NEXT,        ST_CLR_LOOP,  1'b0};
            ST_CLR_LOOP:  w = '{UOP_CLR_LOOP,   COND_WAIT_LAST,   ST_DONE,      1'b0};
            ST_DONE:      w = '{UOP_EMIT,       COND_WAIT_OUT,    ST_IDLE,      1'b0};
            default:      w = '{UOP_LATCH,      COND_JUMP,        ST_IDLE,      1'b0};
        endcase
        return w;
    endfunction

endpackage

// ----- src/tcw_stream_if.sv -----
// tcw_stream_if: valid/ready channel carrying one item of type T.
// Depends on nothing; the item types come from tcw_pkg at instantiation.
interface tcw_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/tcw_screen_ram.sv -----
// tcw_screen_ram: character store, one write and one registered read port.
// Depends on nothing.
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tcw_sequencer.sv -----
// tcw_sequencer: step counter over the microprogram in tcw_pkg, with
// conditional jumps and command dispatch. Depends on tcw_pkg.
module tcw_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [tcw_pkg::CMD_W-1:0]    i_cmd,
    input  tcw_pkg::t_stat               i_stat,
    output tcw_pkg::t_ctrl               o_ctrl
);

    tcw_pkg::t_step  r_step;
    tcw_pkg::t_step  n_step;
    tcw_pkg::t_step  dispatch;
    tcw_pkg::t_uword w;

    // current control word
    always_comb begin
        w = tcw_pkg::ucode(r_step);
    end

    // entry step of each command
    always_comb begin
        unique case (i_cmd)
            tcw_pkg::CMD_PUT:   dispatch = tcw_pkg::ST_PUT;
            tcw_pkg::CMD_READ:  dispatch = tcw_pkg::ST_READ;
            tcw_pkg::CMD_CLEAR: dispatch = tcw_pkg::ST_CLR_INIT;
            default:            dispatch = tcw_pkg::ST_DONE;
        endcase
    end

    // next step
    always_comb begin
        unique case (w.cond)
            tcw_pkg::COND_NEXT:        n_step = tcw_pkg::t_step'(4'(r_step) + 4'd1);
            tcw_pkg::COND_JUMP:        n_step = w.target;
            tcw_pkg::COND_BR_NOSCROLL: n_step = i_stat.no_scroll ? w.target
                                              : tcw_pkg::t_step'(4'(r_step) + 4'd1);
            tcw_pkg::COND_WAIT_LAST:   n_step = i_stat.last ? w.target : r_step;
            tcw_pkg::COND_WAIT_OUT:    n_step = i_stat.out_free ? w.target : r_step;
            tcw_pkg::COND_DISPATCH:    n_step = i_accept ? dispatch : r_step;
            default:                   n_step = tcw_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ctrl.uop      = w.uop;
        o_ctrl.in_ready = w.in_ready;
    end

    // step counter, starts with the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tcw_pkg::ST_BOOT_INIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- src/tcw_datapath.sv -----
// tcw_datapath: cursor, sweep address, store port drive and result register.
// Depends on tcw_pkg; driven by tcw_sequencer, drives tcw_screen_ram.
module tcw_datapath #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 8,
    parameter int AW       = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcw_pkg::t_ctrl       i_ctrl,
    input  logic                 i_accept,
    input  tcw_pkg::t_cmd_item   i_item,
    output tcw_pkg::t_stat       o_stat,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [7:0]           o_wdata,
    output logic                 o_re,
    output logic [AW-1:0]        o_raddr,
    input  logic [7:0]           i_rdata,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tcw_pkg::t_res_item   o_out_item
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RTW   = $clog2(ROWS + 1);
    localparam int CTW   = $clog2(COLUMNS + TAB_STEP);

    logic [RW-1:0]                 r_row;
    logic [CW-1:0]                 r_col;
    logic [AW-1:0]                 r_addr;
    logic [tcw_pkg::CHAR_W-1:0]    r_code;
    logic [tcw_pkg::ROW_W-1:0]     r_rrow;
    logic [tcw_pkg::COL_W-1:0]     r_rcol;
    logic [tcw_pkg::CHAR_W-1:0]    r_char;
    logic                          r_out_valid;
    tcw_pkg::t_res_item            r_out_item;

    logic [CTW-1:0]                col_t;
    logic [RTW-1:0]                row_t;
    logic [CW-1:0]                 col_wr;
    logic                          put_we;
    logic [7:0]                    put_data;
    logic                          put_scroll;
    logic [AW-1:0]                 put_addr;
    logic                          rd_in_range;
    logic [AW-1:0]                 rd_addr;
    logic                          last;
    logic                          out_free;

    // cursor step for the put command
    always_comb begin
        col_t    = CTW'(r_col);
        row_t    = RTW'(r_row);
        col_wr   = r_col;
        put_we   = 1'b0;
        put_data = r_code;
        if (r_code >= tcw_pkg::CH_FIRST && r_code <= tcw_pkg::CH_LAST) begin
            put_we = 1'b1;
            col_t  = CTW'(r_col) + CTW'(1);
        end else if (r_code == tcw_pkg::CH_NL) begin
            row_t = RTW'(r_row) + RTW'(1);
            col_t = '0;
        end else if (r_code == tcw_pkg::CH_SPACE) begin
            col_t = CTW'(r_col) + CTW'(1);
        end else if (r_code == tcw_pkg::CH_BS) begin
            if (r_col != '0) begin
                col_t    = CTW'(r_col) - CTW'(1);
                col_wr   = r_col - CW'(1);
                put_we   = 1'b1;
                put_data = tcw_pkg::CH_SPACE;
            end
        end else if (r_code == tcw_pkg::CH_TAB) begin
            col_t = CTW'(r_col) + CTW'(TAB_STEP);
        end
        // line wrap
        if (32'(col_t) >= COLUMNS) begin
            row_t = row_t + RTW'(1);
            col_t = '0;
        end
        put_scroll = 32'(row_t) >= ROWS;
        put_addr   = AW'(32'(r_row) * COLUMNS + 32'(col_wr));
    end

    // read address and range check
    always_comb begin
        rd_in_range = (32'(r_rrow) < ROWS) && (32'(r_rcol) < COLUMNS);
        rd_addr     = AW'(32'(r_rrow) * COLUMNS + 32'(r_rcol));
    end

    // end of a sweep
    always_comb begin
        unique case (i_ctrl.uop)
            tcw_pkg::UOP_CLR_LOOP,
            tcw_pkg::UOP_FILL:     last = (r_addr == AW'(CELLS - 1));
            tcw_pkg::UOP_SCR_COPY: last = (r_addr == AW'((ROWS - 1) * COLUMNS - 1));
            default:               last = 1'b0;
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.last      = last;
        o_stat.no_scroll = !put_scroll;
        o_stat.out_free  = out_free;
    end

    // store port drive
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_addr;
        o_wdata = tcw_pkg::CH_ZERO;
        o_re    = 1'b0;
        o_raddr = rd_addr;
        unique case (i_ctrl.uop)
            tcw_pkg::UOP_CLR_LOOP: begin
                o_we = 1'b1;
            end
            tcw_pkg::UOP_PUT: begin
                o_we    = put_we;
                o_waddr = put_addr;
                o_wdata = put_data;
            end
            tcw_pkg::UOP_SCR_INIT: begin
                o_re    = 1'b1;
                o_raddr = AW'(COLUMNS);
            end
            tcw_pkg::UOP_SCR_COPY: begin
                // copy the cell of the row below into this one, fetch one cell ahead
                o_we    = 1'b1;
                o_wdata = i_rdata;
                o_re    = !last;
                o_raddr = AW'(32'(r_addr) + COLUMNS + 1);
            end
            tcw_pkg::UOP_FILL: begin
                o_we    = 1'b1;
                o_wdata = tcw_pkg::CH_SPACE;
            end
            tcw_pkg::UOP_RD_ISSUE: begin
                o_re = rd_in_range;
            end
            default: begin
            end
        endcase
    end

    // result valid flag: loading a new item wins over draining the old one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.uop == tcw_pkg::UOP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_addr      <= '0;
        end else begin
            unique case (i_ctrl.uop)
                tcw_pkg::UOP_CLR_INIT: begin
                    r_addr <= '0;
                    r_row  <= '0;
                    r_col  <= '0;
                end
                tcw_pkg::UOP_CLR_LOOP,
                tcw_pkg::UOP_SCR_COPY,
                tcw_pkg::UOP_FILL: begin
                    r_addr <= r_addr + AW'(1);
                end
                tcw_pkg::UOP_LATCH: begin
                    if (i_accept) begin
                        r_code <= i_item.char_code;
                        r_rrow <= i_item.read_row;
                        r_rcol <= i_item.read_col;
                        r_char <= tcw_pkg::CH_ZERO;
                    end
                end
                tcw_pkg::UOP_PUT: begin
                    if (put_scroll) begin
                        r_row <= RW'(ROWS - 1);
                        r_col <= '0;
                    end else begin
                        r_row <= RW'(row_t);
                        r_col <= CW'(col_t);
                    end
                end
                tcw_pkg::UOP_SCR_INIT: begin
                    r_addr <= '0;
                end
                tcw_pkg::UOP_RD_CAPTURE: begin
                    r_char <= rd_in_range ? i_rdata : tcw_pkg::CH_ZERO;
                end
                tcw_pkg::UOP_EMIT: begin
                    if (out_free) begin
                        r_out_item.cursor_row      <= (tcw_pkg::ROW_W)'(r_row);
                        r_out_item.cursor_col      <= (tcw_pkg::COL_W)'(r_col);
                        r_out_item.cursor_position <=
                            (tcw_pkg::POS_W)'(32'(r_row) * COLUMNS + 32'(r_col));
                        r_out_item.read_char       <= r_char;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- src/text_console_writer.sv -----
// Text console writer: ROWS x COLUMNS character store with a cursor.
// A put goes through its step and the done step, an unused command straight to done,
// a read through issue, capture and done; clear and a scrolling put sweep the store first.
// A new item is taken only in the idle step that follows loading a result into the output
// register; the cost is set by one store cell per cycle in the sweeps.
// Reset: synchronous, then a clearing pass of the store, ready low.
module text_console_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcw_stream_if.sink   i_cmd,
    tcw_stream_if.source o_res
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    tcw_pkg::t_ctrl ctrl;
    tcw_pkg::t_stat stat;
    logic           accept;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [7:0]     wdata;
    logic           re;
    logic [AW-1:0]  raddr;
    logic [7:0]     rdata;

    // input handshake
    assign i_cmd.ready = ctrl.in_ready;
    assign accept      = i_cmd.valid && ctrl.in_ready;

    tcw_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_cmd.data.cmd),
        .i_stat   (stat),
        .o_ctrl   (ctrl)
    );

    tcw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP),
        .AW       (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_accept    (accept),
        .i_item      (i_cmd.data),
        .o_stat      (stat),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_out_item  (o_res.data)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

// ----- src/tcw_checker.sv -----
// tcw_checker: port-level assertions for text_console_writer, bound below.
// Depends on tcw_pkg and text_console_writer.
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input tcw_pkg::t_res_item i_out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result changed while stalled");

    // one item at a time: busy right after an item is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken while previous one in work");

    // cursor stays on screen
    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_out_item.cursor_row) < ROWS)
                     && (32'(i_out_item.cursor_col) < COLUMNS))
        else $error("cursor off screen");

    // linear position agrees with row and column
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (ROWS <= 32) |-> i_out_item.cursor_position ==
            11'(32'(i_out_item.cursor_row) * COLUMNS + 32'(i_out_item.cursor_col)))
        else $error("cursor position mismatch");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_item  (o_res.data)
);
